// ===== rtl/vdir_pkg.sv =====
// Shared types, constants and command/status structs for the vertex dedup block.
package vdir_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned FLT_W            = 32;
  localparam int unsigned IDX_IN_W         = 16;
  localparam int unsigned RES_W            = 10;
  localparam int unsigned REQ_W            = 2;
  localparam int unsigned STS_W            = 2;
  localparam int unsigned CFG_IDX_W        = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_REMAP = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_BADIDX = 2'd2
  } sts_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UV     = 2'd0,
    CFG_NORMAL = 2'd1,
    CFG_COLOR  = 2'd2
  } cfg_idx_e;

  // What goes into the result register when a beat is finished
  typedef enum logic [2:0] {
    KIND_LOAD,
    KIND_FULL,
    KIND_REMAP,
    KIND_BADIDX,
    KIND_ZERO
  } out_kind_e;

  typedef struct packed {
    logic [FLT_W-1:0] pos_x;
    logic [FLT_W-1:0] pos_y;
    logic [FLT_W-1:0] pos_z;
    logic [FLT_W-1:0] tex_u;
    logic [FLT_W-1:0] tex_v;
    logic [FLT_W-1:0] norm_x;
    logic [FLT_W-1:0] norm_y;
    logic [FLT_W-1:0] norm_z;
    logic [FLT_W-1:0] color;
  } vtx_t;

  typedef struct packed {
    logic      in_ready;
    logic      latch;
    logic      scan_start;
    logic      scan_en;
    logic      take_hit;
    logic      take_own;
    logic      store;
    logic      clear;
    logic      remap_rd;
    logic      out_load;
    out_kind_e out_kind;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic full;
    logic empty;
    logic idx_ok;
    logic cmp_valid;
    logic cmp_match;
    logic cmp_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/vdir_if.sv =====
// Request, response and configuration channel interfaces.
interface vdir_req_if;
  logic                           valid;
  logic                           ready;
  logic [vdir_pkg::REQ_W-1:0]     req_type;
  logic [vdir_pkg::FLT_W-1:0]     pos_x;
  logic [vdir_pkg::FLT_W-1:0]     pos_y;
  logic [vdir_pkg::FLT_W-1:0]     pos_z;
  logic [vdir_pkg::FLT_W-1:0]     tex_u;
  logic [vdir_pkg::FLT_W-1:0]     tex_v;
  logic [vdir_pkg::FLT_W-1:0]     norm_x;
  logic [vdir_pkg::FLT_W-1:0]     norm_y;
  logic [vdir_pkg::FLT_W-1:0]     norm_z;
  logic [vdir_pkg::FLT_W-1:0]     color_word;
  logic [vdir_pkg::IDX_IN_W-1:0]  index_in;

  modport source (
    output valid, req_type, pos_x, pos_y, pos_z, tex_u, tex_v,
           norm_x, norm_y, norm_z, color_word, index_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, pos_z, tex_u, tex_v,
           norm_x, norm_y, norm_z, color_word, index_in,
    output ready
  );
endinterface

interface vdir_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [vdir_pkg::RES_W-1:0]  result_index;
  logic                        is_duplicate;
  logic [vdir_pkg::STS_W-1:0]  status;

  modport source (output valid, result_index, is_duplicate, status, input ready);
  modport sink   (input valid, result_index, is_duplicate, status, output ready);
endinterface

interface vdir_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vdir_pkg::CFG_IDX_W-1:0]  reg_idx;
  logic                            wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// ===== rtl/vdir_ctrl.sv =====
// Controller state machine: sequences load, remap and clear beats.
module vdir_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  vdir_pkg::sts_t  sts_i,
  output vdir_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e              state_q, state_d;
  vdir_pkg::out_kind_e kind_q, kind_d;

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = kind_q;
    state_d        = state_q;
    kind_d         = kind_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_FINISH;
        case (sts_i.req)
          vdir_pkg::REQ_LOAD: begin
            if (sts_i.full) begin
              kind_d = vdir_pkg::KIND_FULL;
            end else if (sts_i.empty) begin
              cmd_o.take_own = 1'b1;
              kind_d         = vdir_pkg::KIND_LOAD;
            end else begin
              cmd_o.scan_start = 1'b1;
              kind_d           = vdir_pkg::KIND_LOAD;
              state_d          = ST_SCAN;
            end
          end
          vdir_pkg::REQ_REMAP: begin
            if (sts_i.idx_ok) begin
              cmd_o.remap_rd = 1'b1;
              kind_d         = vdir_pkg::KIND_REMAP;
            end else begin
              kind_d = vdir_pkg::KIND_BADIDX;
            end
          end
          vdir_pkg::REQ_CLEAR: begin
            cmd_o.clear = 1'b1;
            kind_d      = vdir_pkg::KIND_ZERO;
          end
          default: begin
            kind_d = vdir_pkg::KIND_ZERO;
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.cmp_valid && sts_i.cmp_match) begin
          cmd_o.take_hit = 1'b1;
          state_d        = ST_FINISH;
        end else if (sts_i.cmp_valid && sts_i.cmp_last) begin
          cmd_o.take_own = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.store    = (kind_q == vdir_pkg::KIND_LOAD);
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= vdir_pkg::KIND_ZERO;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== rtl/vdir_datapath.sv =====
// Datapath: vertex store, canonical table, scan compare, config and result register.
module vdir_datapath #(
  parameter int unsigned MAX_VERTICES = vdir_pkg::MAX_VERTICES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  vdir_req_if.sink         req,
  vdir_rsp_if.source       rsp,
  vdir_cfg_if.sink         cfg,
  input  vdir_pkg::cmd_t   cmd_i,
  output vdir_pkg::sts_t   sts_o
);

  localparam int unsigned IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned FW    = vdir_pkg::FLT_W;
  localparam int unsigned RW    = vdir_pkg::RES_W;

  function automatic logic is_nan(input logic [FW-1:0] a);
    is_nan = (&a[FW-2:FW-9]) && (|a[FW-10:0]);
  endfunction

  function automatic logic feq(input logic [FW-1:0] a, input logic [FW-1:0] b);
    logic both_zero;
    both_zero = (a[FW-2:0] == '0) && (b[FW-2:0] == '0);
    feq = !is_nan(a) && !is_nan(b) && (both_zero || (a == b));
  endfunction

  vdir_pkg::vtx_t vtx_mem   [MAX_VERTICES];
  logic [RW-1:0]  canon_mem [MAX_VERTICES];

  vdir_pkg::vtx_t                vtx_q, rd_vtx_q;
  vdir_pkg::req_e                req_q;
  logic [vdir_pkg::IDX_IN_W-1:0] idx_in_q;
  logic [CNT_W-1:0]              count_q;
  logic [IDX_W-1:0]              ptr_q, ridx_q, canon_q;
  logic                          iss_on_q, rv_q, dup_q;
  logic [RW-1:0]                 cread_q;
  logic                          cmp_uv_q, cmp_nrm_q, cmp_col_q;
  logic                          out_valid_q, out_dup_q;
  logic [RW-1:0]                 out_res_q;
  logic [vdir_pkg::STS_W-1:0]    out_sts_q;

  logic issue, last_issue, match;

  assign issue      = cmd_i.scan_en && iss_on_q;
  assign last_issue = (CNT_W'(ptr_q) + CNT_W'(1)) == count_q;

  always_comb begin
    match = feq(rd_vtx_q.pos_x, vtx_q.pos_x) && feq(rd_vtx_q.pos_y, vtx_q.pos_y) &&
            feq(rd_vtx_q.pos_z, vtx_q.pos_z);
    if (cmp_uv_q) begin
      match = match && feq(rd_vtx_q.tex_u, vtx_q.tex_u) && feq(rd_vtx_q.tex_v, vtx_q.tex_v);
    end
    if (cmp_nrm_q) begin
      match = match && feq(rd_vtx_q.norm_x, vtx_q.norm_x) &&
              feq(rd_vtx_q.norm_y, vtx_q.norm_y) && feq(rd_vtx_q.norm_z, vtx_q.norm_z);
    end
    if (cmp_col_q) begin
      match = match && (rd_vtx_q.color == vtx_q.color);
    end
  end

  assign sts_o.req       = req_q;
  assign sts_o.full      = (count_q == CNT_W'(MAX_VERTICES));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.idx_ok    = (32'(idx_in_q) < 32'(count_q));
  assign sts_o.cmp_valid = rv_q;
  assign sts_o.cmp_match = match;
  assign sts_o.cmp_last  = (CNT_W'(ridx_q) + CNT_W'(1)) == count_q;
  assign sts_o.out_busy  = out_valid_q && !rsp.ready;

  assign cfg.ready        = 1'b1;
  assign rsp.valid        = out_valid_q;
  assign rsp.result_index = out_res_q;
  assign rsp.is_duplicate = out_dup_q;
  assign rsp.status       = out_sts_q;

  // Store memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      vtx_mem[count_q[IDX_W-1:0]]   <= vtx_q;
      canon_mem[count_q[IDX_W-1:0]] <= RW'(canon_q);
    end
    if (issue) begin
      rd_vtx_q <= vtx_mem[ptr_q];
    end
    if (cmd_i.remap_rd) begin
      cread_q <= canon_mem[idx_in_q[IDX_W-1:0]];
    end
  end

  // Beat payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q        <= vdir_pkg::req_e'(req.req_type);
      idx_in_q     <= req.index_in;
      vtx_q.pos_x  <= req.pos_x;
      vtx_q.pos_y  <= req.pos_y;
      vtx_q.pos_z  <= req.pos_z;
      vtx_q.tex_u  <= req.tex_u;
      vtx_q.tex_v  <= req.tex_v;
      vtx_q.norm_x <= req.norm_x;
      vtx_q.norm_y <= req.norm_y;
      vtx_q.norm_z <= req.norm_z;
      vtx_q.color  <= req.color_word;
    end
    if (issue) begin
      ridx_q <= ptr_q;
    end
    if (cmd_i.take_hit) begin
      canon_q <= ridx_q;
      dup_q   <= 1'b1;
    end else if (cmd_i.take_own) begin
      canon_q <= count_q[IDX_W-1:0];
      dup_q   <= 1'b0;
    end
    if (cmd_i.out_load) begin
      case (cmd_i.out_kind)
        vdir_pkg::KIND_LOAD: begin
          out_res_q <= RW'(canon_q);
          out_dup_q <= dup_q;
          out_sts_q <= vdir_pkg::STS_OK;
        end
        vdir_pkg::KIND_FULL: begin
          out_res_q <= '0;
          out_dup_q <= 1'b0;
          out_sts_q <= vdir_pkg::STS_FULL;
        end
        vdir_pkg::KIND_REMAP: begin
          out_res_q <= cread_q;
          out_dup_q <= 1'b0;
          out_sts_q <= vdir_pkg::STS_OK;
        end
        vdir_pkg::KIND_BADIDX: begin
          out_res_q <= '0;
          out_dup_q <= 1'b0;
          out_sts_q <= vdir_pkg::STS_BADIDX;
        end
        default: begin
          out_res_q <= '0;
          out_dup_q <= 1'b0;
          out_sts_q <= vdir_pkg::STS_OK;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      iss_on_q    <= 1'b0;
      rv_q        <= 1'b0;
      cmp_uv_q    <= 1'b0;
      cmp_nrm_q   <= 1'b0;
      cmp_col_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.store) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        ptr_q    <= '0;
        iss_on_q <= 1'b1;
        rv_q     <= 1'b0;
      end else begin
        rv_q <= issue;
        if (issue) begin
          if (last_issue) begin
            iss_on_q <= 1'b0;
          end else begin
            ptr_q <= ptr_q + IDX_W'(1);
          end
        end
      end
      if (cfg.valid) begin
        case (cfg.reg_idx)
          vdir_pkg::CFG_UV:     cmp_uv_q  <= cfg.wdata;
          vdir_pkg::CFG_NORMAL: cmp_nrm_q <= cfg.wdata;
          vdir_pkg::CFG_COLOR:  cmp_col_q <= cfg.wdata;
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_VERTICES)
    else $error("vertex count above capacity");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (32'(count_q) < MAX_VERTICES))
    else $error("store into a full table");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !rsp.ready))
    else $error("result register overwritten while stalled");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_hit) |-> (CNT_W'(ridx_q) < count_q))
    else $error("match reported beyond stored vertices");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (count_q == '0))
    else $error("clear did not empty the table");

endmodule

// ===== rtl/vertex_dedup_index_remap_core.sv =====
// Top level of the vertex deduplication and index remap block.
// Channels: req_i takes one beat per request (load vertex, remap index, clear),
// rsp_o returns exactly one result beat per request, in order; cfg_i writes the
// three compare enables (uv, normal, colour), taken at once; the user must write
// them only while idle, as the block itself does not enforce it. A load beat
// scans the stored vertices from index 0 with one compare per cycle on the
// vertex memory's single read port; it stops at the first match. An empty or
// full table needs no scan, nor do remap and clear beats.
// One request is in flight at a time; req_i is ready again once the result sits
// in the output register, so the next beat is taken while rsp_o stalls; its
// result then waits until the previous one has been taken.
// Reset empties the table and clears the compare enables; the memories are
// not swept, entries beyond the fill count are never read.
module vertex_dedup_index_remap_core #(
  parameter int unsigned MAX_VERTICES = vdir_pkg::MAX_VERTICES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vdir_req_if.sink     req_i,
  vdir_rsp_if.source   rsp_o,
  vdir_cfg_if.sink     cfg_i
);

  vdir_pkg::cmd_t cmd;
  vdir_pkg::sts_t sts;

  assign req_i.ready = cmd.in_ready;

  vdir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vdir_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .rsp    (rsp_o),
    .cfg    (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for vertex_dedup_index_remap_core: random and directed beats vs predictor.
module tb;

  localparam int unsigned MAX_VTX     = vdir_pkg::MAX_VERTICES_DEF;
  localparam int unsigned VIDX_W      = $clog2(MAX_VTX);
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    vdir_pkg::req_e                req;
    vdir_pkg::vtx_t                v;
    logic [vdir_pkg::IDX_IN_W-1:0] idx;
  } vertex_req_t;

  typedef struct packed {
    logic [vdir_pkg::RES_W-1:0] res_idx;
    logic                       dup;
    vdir_pkg::sts_code_e        status;
  } dedup_result_t;

  class dedup_scoreboard;
    vdir_pkg::vtx_t             vtx_mem [MAX_VTX];
    logic [vdir_pkg::RES_W-1:0] canon_of [MAX_VTX];
    int unsigned                vtx_count;
    bit                         use_uv, use_normal, use_color;
    dedup_result_t              expected_q [$];
    int unsigned                errors;

    function void set_compare(vdir_pkg::cfg_idx_e sel, bit en);
      case (sel)
        vdir_pkg::CFG_UV:     use_uv = en;
        vdir_pkg::CFG_NORMAL: use_normal = en;
        vdir_pkg::CFG_COLOR:  use_color = en;
        default: ;
      endcase
    endfunction

    static function bit float_same(logic [31:0] a, logic [31:0] b);
      bit a_nan, b_nan;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      if (a_nan || b_nan) return 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b1;
      return a == b;
    endfunction

    function bit vertex_hit(int unsigned k, vdir_pkg::vtx_t v);
      vdir_pkg::vtx_t s;
      s = vtx_mem[k[VIDX_W-1:0]];
      if (!(float_same(s.pos_x, v.pos_x) && float_same(s.pos_y, v.pos_y) &&
            float_same(s.pos_z, v.pos_z)))
        return 1'b0;
      if (use_uv && !(float_same(s.tex_u, v.tex_u) && float_same(s.tex_v, v.tex_v)))
        return 1'b0;
      if (use_normal && !(float_same(s.norm_x, v.norm_x) &&
                          float_same(s.norm_y, v.norm_y) &&
                          float_same(s.norm_z, v.norm_z)))
        return 1'b0;
      if (use_color && s.color != v.color) return 1'b0;
      return 1'b1;
    endfunction

    function void note_request(vertex_req_t b);
      dedup_result_t r;
      int unsigned   canon;
      int unsigned   k;
      r.res_idx = '0;
      r.dup     = 1'b0;
      r.status  = vdir_pkg::STS_OK;
      case (b.req)
        vdir_pkg::REQ_LOAD: begin
          if (vtx_count >= MAX_VTX) begin
            r.status = vdir_pkg::STS_FULL;
          end else begin
            canon = vtx_count;
            for (k = 0; k < vtx_count; k++) begin
              if (vertex_hit(k, b.v)) begin
                canon = k;
                r.dup = 1'b1;
                break;
              end
            end
            vtx_mem[vtx_count[VIDX_W-1:0]]  = b.v;
            canon_of[vtx_count[VIDX_W-1:0]] = canon[vdir_pkg::RES_W-1:0];
            vtx_count++;
            r.res_idx = canon[vdir_pkg::RES_W-1:0];
          end
        end
        vdir_pkg::REQ_REMAP: begin
          if (b.idx < vtx_count) r.res_idx = canon_of[b.idx[VIDX_W-1:0]];
          else r.status = vdir_pkg::STS_BADIDX;
        end
        vdir_pkg::REQ_CLEAR: vtx_count = 0;
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_result(logic [vdir_pkg::RES_W-1:0] res_idx, logic dup,
                               logic [vdir_pkg::STS_W-1:0] st);
      dedup_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: result_index %0d is_duplicate %0d status %0d",
               res_idx, dup, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (res_idx !== e.res_idx) begin
        $error("result_index: expected %0d, got %0d", e.res_idx, res_idx);
        errors++;
      end
      if (dup !== e.dup) begin
        $error("is_duplicate: expected %0d, got %0d", e.dup, dup);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  vdir_req_if req_bus ();
  vdir_rsp_if rsp_bus ();
  vdir_cfg_if cfg_bus ();

  vertex_dedup_index_remap_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  dedup_scoreboard sb = new;

  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    stall_request;
  int unsigned    hold_left;
  int unsigned    cycle_cnt;
  vdir_pkg::vtx_t mesh_q [$];
  int unsigned    mesh_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (stall_request != 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      rsp_bus.ready = 1'b0;
      hold_left--;
    end else begin
      rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      sb.check_result(rsp_bus.result_index, rsp_bus.is_duplicate, rsp_bus.status);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("vertex_dedup_index_remap_core test failed");
    $finish;
  end

  function automatic vertex_req_t mk_req(vdir_pkg::req_e r, vdir_pkg::vtx_t v,
                                         logic [vdir_pkg::IDX_IN_W-1:0] i);
    vertex_req_t b;
    b.req = r;
    b.v   = v;
    b.idx = i;
    return b;
  endfunction

  function automatic logic [vdir_pkg::IDX_IN_W-1:0] rand_idx();
    return vdir_pkg::IDX_IN_W'($urandom);
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(15))
      0, 1: f = {f[31], 31'd0};
      2:    f = {f[31], 8'hFF, f[22:0] | 23'd1};
      3:    f = {f[31], 8'hFF, 23'd0};
      4, 5: f = {f[31], 8'h7F, 23'd0};
      6:    f = {f[31], 8'h00, f[22:0]};
      default: ;
    endcase
    return f;
  endfunction

  function automatic vdir_pkg::vtx_t rand_vertex();
    logic [8:0][31:0] w;
    for (int j = 0; j < 9; j++) w[j] = rand_float();
    return vdir_pkg::vtx_t'(w);
  endfunction

  // copy of a stored vertex: some zero signs flipped, now and then one word changed
  function automatic vdir_pkg::vtx_t twin_of(vdir_pkg::vtx_t v);
    logic [8:0][31:0] w;
    w = v;
    for (int j = 1; j < 9; j++) begin
      if (w[j][30:0] == 31'd0 && $urandom_range(1) == 1) w[j][31] = ~w[j][31];
    end
    if ($urandom_range(3) == 0) w[$urandom_range(8)] = rand_float();
    return vdir_pkg::vtx_t'(w);
  endfunction

  task automatic send_req(vertex_req_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid      = 1'b1;
    req_bus.req_type   = b.req;
    req_bus.pos_x      = b.v.pos_x;
    req_bus.pos_y      = b.v.pos_y;
    req_bus.pos_z      = b.v.pos_z;
    req_bus.tex_u      = b.v.tex_u;
    req_bus.tex_v      = b.v.tex_v;
    req_bus.norm_x     = b.v.norm_x;
    req_bus.norm_y     = b.v.norm_y;
    req_bus.norm_z     = b.v.norm_z;
    req_bus.color_word = b.v.color;
    req_bus.index_in   = b.idx;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(b);
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    req_bus.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_config(bit uv, bit nrm, bit col);
    vdir_pkg::cfg_idx_e sel [3];
    bit                 val [3];
    sel = '{vdir_pkg::CFG_UV, vdir_pkg::CFG_NORMAL, vdir_pkg::CFG_COLOR};
    val = '{uv, nrm, col};
    cfg_bus.valid = 1'b1;
    for (int j = 0; j < 3; j++) begin
      cfg_bus.reg_idx = sel[j];
      cfg_bus.wdata   = val[j];
      do @(posedge clk_i); while (!cfg_bus.ready);
      sb.set_compare(sel[j], val[j]);
      @(negedge clk_i);
    end
    cfg_bus.valid = 1'b0;
  endtask

  task automatic run_segment(int unsigned n_items);
    int unsigned                   sent;
    int unsigned                   roll;
    vdir_pkg::vtx_t                v;
    logic [vdir_pkg::IDX_IN_W-1:0] ri;
    sent = 0;
    while (sent < n_items) begin
      if (mesh_left == 0) begin
        send_req(mk_req(vdir_pkg::REQ_CLEAR, rand_vertex(), rand_idx()));
        mesh_q.delete();
        mesh_left = ($urandom_range(11) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
        sent++;
      end
      roll = $urandom_range(99);
      if (roll < 68) begin
        if (mesh_q.size() != 0 && $urandom_range(99) < 55)
          v = twin_of(mesh_q[$urandom_range(mesh_q.size() - 1)]);
        else
          v = rand_vertex();
        send_req(mk_req(vdir_pkg::REQ_LOAD, v, rand_idx()));
        mesh_q = {mesh_q, v};
        mesh_left--;
      end else if (roll < 92) begin
        ri = ($urandom_range(4) == 0) ? rand_idx() :
             vdir_pkg::IDX_IN_W'($urandom_range(0, mesh_q.size() + 1));
        send_req(mk_req(vdir_pkg::REQ_REMAP, rand_vertex(), ri));
      end else if (roll < 97) begin
        send_req(mk_req(vdir_pkg::REQ_NONE, rand_vertex(), rand_idx()));
      end else begin
        send_req(mk_req(vdir_pkg::REQ_CLEAR, rand_vertex(), rand_idx()));
        mesh_q.delete();
        mesh_left = 0;
      end
      sent++;
    end
  endtask

  initial begin
    vdir_pkg::vtx_t v_zero, v_negz, v_nan, v_ones, v_inf, v_tmp;
    int unsigned    send_pct [3];
    int unsigned    recv_pct [3];
    send_pct = '{12, 73, 0};
    recv_pct = '{73, 12, 0};

    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = vdir_pkg::REQ_LOAD;
    req_bus.pos_x      = '0;
    req_bus.pos_y      = '0;
    req_bus.pos_z      = '0;
    req_bus.tex_u      = '0;
    req_bus.tex_v      = '0;
    req_bus.norm_x     = '0;
    req_bus.norm_y     = '0;
    req_bus.norm_z     = '0;
    req_bus.color_word = '0;
    req_bus.index_in   = '0;
    rsp_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.reg_idx    = vdir_pkg::CFG_UV;
    cfg_bus.wdata      = 1'b0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    stall_request      = 0;
    hold_left          = 0;
    mesh_left          = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: signed zeros, NaN, infinity, per-attribute compare, bad indices
    write_config(1'b1, 1'b1, 1'b1);
    v_zero = '0;
    v_negz = {{8{32'h8000_0000}}, 32'h0};
    v_nan  = '0;
    v_nan.pos_x = 32'h7FC0_0000;
    v_ones = '1;
    v_inf  = '0;
    v_inf.pos_x = 32'h7F80_0000;
    v_inf.pos_y = 32'h7F80_0000;
    v_inf.pos_z = 32'hFF80_0000;
    send_req(mk_req(vdir_pkg::REQ_REMAP, v_zero, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_REMAP, v_zero, 16'hFFFF));
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_zero, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_negz, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_nan, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_nan, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_ones, 16'hFFFF));
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_inf, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_inf, 16'h0000));
    v_tmp = v_zero;
    v_tmp.color = 32'hFFFF_FFFF;
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_tmp, 16'h0000));
    v_tmp = v_zero;
    v_tmp.tex_u = 32'h3F80_0000;
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_tmp, 16'h0000));
    v_tmp = v_zero;
    v_tmp.norm_z = 32'h0000_0001;
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_tmp, 16'h0000));
    v_tmp = v_negz;
    v_tmp.color = 32'hFFFF_FFFF;
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_tmp, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_REMAP, v_zero, 16'd1));
    send_req(mk_req(vdir_pkg::REQ_REMAP, v_zero, 16'd9));
    send_req(mk_req(vdir_pkg::REQ_REMAP, v_zero, 16'd10));
    send_req(mk_req(vdir_pkg::REQ_NONE, v_ones, 16'hFFFF));
    send_req(mk_req(vdir_pkg::REQ_CLEAR, v_zero, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_REMAP, v_zero, 16'h0000));
    v_tmp = {{8{32'h7F7F_FFFF}}, 32'h8000_0001};
    send_req(mk_req(vdir_pkg::REQ_LOAD, v_tmp, 16'h0000));
    send_req(mk_req(vdir_pkg::REQ_REMAP, v_zero, 16'h0000));

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      for (int seg = 0; seg < 2; seg++) begin
        quiesce();
        if (p == 0 && seg == 0) write_config(1'b0, 1'b0, 1'b0);
        else if (p == 0) write_config(1'b1, 1'b1, 1'b1);
        else write_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
        if (p == 0 && seg == 0) stall_request = 300;
        run_segment(95);
      end
    end

    quiesce();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("vertex_dedup_index_remap_core test passed");
    end else begin
      $display("vertex_dedup_index_remap_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vdir_pkg.sv
rtl/vdir_if.sv
rtl/vdir_ctrl.sv
rtl/vdir_datapath.sv
rtl/vertex_dedup_index_remap_core.sv
verif/tb.sv
